// ----- rtl/core/mdt_pkg.sv -----
package mdt_pkg;

  // Register file layout
  localparam int REG_SLOTS   = 4;
  localparam int PAT_BYTES   = 4;
  localparam int LEN_W       = 3;
  localparam int SLOT_W      = 2;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  // Register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_ZERO  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_ONE   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_TWO   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_THREE = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SLOT_LENGTHS  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_EMIT_DELIMS   = 3'd5;

  typedef enum logic {
    KIND_DATA = 1'b0,
    KIND_END  = 1'b1
  } in_kind_t;

  typedef enum logic [1:0] {
    OUT_TOKEN_BYTE  = 2'd0,
    OUT_TOKEN_END   = 2'd1,
    OUT_DELIM_BYTE  = 2'd2,
    OUT_EMPTY_TOKEN = 2'd3
  } out_kind_t;

  // One input item
  typedef struct packed {
    in_kind_t   kind;
    logic [7:0] in_byte;
  } item_t;

  // One result item
  typedef struct packed {
    out_kind_t         out_kind;
    logic [7:0]        out_byte;
    logic [SLOT_W-1:0] slot_hit;
    logic              delim_end;
    logic              run_last;
  } result_t;

  // Configuration register contents
  typedef struct packed {
    logic [REG_SLOTS-1:0][PAT_BYTES*8-1:0] pattern;
    logic [REG_SLOTS*LEN_W-1:0]            slot_lengths;
    logic                                  emit_delims;
  } cfg_t;

  // Outcome of the delimiter search at the window head
  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic [LEN_W-1:0]  len;
  } match_t;

  // One engine step handed to the result stage
  typedef struct packed {
    logic    fire;
    logic    has_result;
    result_t result;
    logic    done;
  } step_t;

endpackage

// ----- rtl/core/mdt_cfg_regs.sv -----
module mdt_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mdt_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [mdt_pkg::CFG_DATA_W-1:0]     cfg_data,
  output mdt_pkg::cfg_t                      cfg
);
  import mdt_pkg::*;

  // The register file takes a write in every cycle.
  assign cfg_ready = 1'b1;

  // Register writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PATTERN_ZERO: begin
          cfg.pattern[0] <= cfg_data[PAT_BYTES*8-1:0];
        end
        REG_PATTERN_ONE: begin
          cfg.pattern[1] <= cfg_data[PAT_BYTES*8-1:0];
        end
        REG_PATTERN_TWO: begin
          cfg.pattern[2] <= cfg_data[PAT_BYTES*8-1:0];
        end
        REG_PATTERN_THREE: begin
          cfg.pattern[3] <= cfg_data[PAT_BYTES*8-1:0];
        end
        REG_SLOT_LENGTHS: begin
          cfg.slot_lengths <= cfg_data[REG_SLOTS*LEN_W-1:0];
        end
        REG_EMIT_DELIMS: begin
          cfg.emit_delims <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/mdt_match.sv -----
module mdt_match #(
  parameter int NUM_SLOTS     = 4,
  parameter int MAX_DELIM_LEN = 4
) (
  input  mdt_pkg::cfg_t                             cfg,
  input  logic [MAX_DELIM_LEN*8-1:0]                window,
  input  logic [$clog2(MAX_DELIM_LEN+1)-1:0]        avail,
  output mdt_pkg::match_t                           match
);
  import mdt_pkg::*;

  localparam int EFF_MAX = (MAX_DELIM_LEN < PAT_BYTES) ? MAX_DELIM_LEN : PAT_BYTES;

  // Window bytes padded out to the pattern width.
  logic [PAT_BYTES-1:0][7:0] wpad;

  for (genvar gi = 0; gi < PAT_BYTES; gi++) begin : g_pad
    if (gi < MAX_DELIM_LEN) begin : g_byte
      assign wpad[gi] = window[8*gi +: 8];
    end else begin : g_zero
      assign wpad[gi] = 8'h00;
    end
  end

  // Compare every slot at the head; scanning downward lets the lowest slot win.
  always_comb begin
    logic [LEN_W-1:0] l;
    logic             ok;
    match = '0;
    for (int s = REG_SLOTS - 1; s >= 0; s--) begin
      l = cfg.slot_lengths[LEN_W*s +: LEN_W];
      if (32'(l) > EFF_MAX) begin
        l = LEN_W'(EFF_MAX);
      end
      ok = (l != '0) && (32'(l) <= 32'(avail)) && (s < NUM_SLOTS);
      for (int i = 0; i < PAT_BYTES; i++) begin
        if ((i < 32'(l)) && (wpad[i] != cfg.pattern[s][8*i +: 8])) begin
          ok = 1'b0;
        end
      end
      if (ok) begin
        match.hit  = 1'b1;
        match.slot = SLOT_W'(s);
        match.len  = l;
      end
    end
  end

endmodule

// ----- rtl/core/mdt_result_stage.sv -----
module mdt_result_stage (
  input  logic              clk,
  input  logic              rst,
  input  mdt_pkg::step_t    step,
  output logic              take,
  output logic              res_valid,
  input  logic              res_ready,
  output mdt_pkg::result_t  res
);
  import mdt_pkg::*;

  // The hold register keeps the newest result of an item until it is known
  // whether another result of the same item follows.
  logic    hold_valid;
  logic    hold_done;
  result_t hold;

  logic    adv;
  logic    flush;
  logic    load;
  result_t hold_fin;
  result_t hold_mid;
  result_t step_fin;

  assign adv   = !res_valid || res_ready;
  assign flush = hold_valid && hold_done;
  assign take  = adv && !flush;

  // A new result enters the output register in this cycle.
  assign load = (flush && adv) ||
                (step.fire && (hold_valid ? (step.has_result || step.done)
                                          : (step.has_result && step.done)));

  // Copies of the held and new results with the end-of-item flag filled in.
  always_comb begin
    hold_fin          = hold;
    hold_fin.run_last = 1'b1;
    hold_mid          = hold;
    hold_mid.run_last = 1'b0;
    step_fin          = step.result;
    step_fin.run_last = 1'b1;
  end

  // Output register and hold register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      hold_valid <= 1'b0;
      hold_done  <= 1'b0;
    end else begin
      if (load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      if (flush && adv) begin
        res        <= hold_fin;
        hold_valid <= 1'b0;
        hold_done  <= 1'b0;
      end else if (step.fire) begin
        if (hold_valid) begin
          if (step.has_result) begin
            res       <= hold_mid;
            hold      <= step.result;
            hold_done <= step.done;
          end else if (step.done) begin
            res        <= hold_fin;
            hold_valid <= 1'b0;
          end
        end else if (step.has_result) begin
          if (step.done) begin
            res <= step_fin;
          end else begin
            hold       <= step.result;
            hold_valid <= 1'b1;
            hold_done  <= 1'b0;
          end
        end
      end
    end
  end

  a_done_needs_hold: assert property (@(posedge clk) disable iff (rst)
    hold_done |-> hold_valid)
    else $error("hold marked finished without a held result");

  a_more_follows: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.run_last) |-> hold_valid)
    else $error("non-final result shown with nothing held behind it");

endmodule

// ----- rtl/core/multi_delimiter_tokenizer.sv -----
// Byte-stream tokenizer with up to four programmable delimiters of one to
// four bytes. Data bytes enter a lookahead window; once the window is full
// its head is either the start of a matching delimiter (earliest position
// first, lowest slot on a tie) or a token byte. Token bytes, token-end
// markers, optional delimiter bytes and an empty-string marker leave on the
// result channel, and run_last flags the last result of each input item.
// An input item that causes at most one result is taken every cycle while
// the result channel is ready and no held result is waiting to leave. An
// item that causes several results occupies the engine for one result at a
// time, and its last result leaves through a one-entry hold register. An
// end of string works through the remaining window decisions, one result at
// a time, and then closes the string; when it causes several results, its
// last one also leaves through the hold register. The single result port
// carries one result per cycle while res_ready is high. Configuration is to
// be written by the user only while the block is idle; the block does not
// enforce this, and the register port always accepts.
module multi_delimiter_tokenizer #(
  parameter int NUM_SLOTS     = 4,
  parameter int MAX_DELIM_LEN = 4
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               item_valid,
  output logic                               item_ready,
  input  mdt_pkg::item_t                     item,
  output logic                               res_valid,
  input  logic                               res_ready,
  output mdt_pkg::result_t                   res,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mdt_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [mdt_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import mdt_pkg::*;

  localparam int WW    = MAX_DELIM_LEN * 8;
  localparam int CNT_W = $clog2(MAX_DELIM_LEN + 1);

  cfg_t   cfg;
  match_t match;
  step_t  step;
  logic   take;

  // Input register
  logic  held_valid;
  item_t held_item;

  // Window and string state
  logic [WW-1:0]    window;
  logic [CNT_W-1:0] window_count;
  logic             token_open;
  logic             seen_byte;

  // Delimiter bytes still to be sent for the current decision
  logic [LEN_W-1:0]       burst_cnt;
  logic [PAT_BYTES*8-1:0] burst_bytes;
  logic [SLOT_W-1:0]      burst_slot;

  logic [WW-1:0]    window_next;
  logic [CNT_W-1:0] window_count_next;
  logic             token_open_next;
  logic             seen_byte_next;

  logic [WW-1:0]    byte_mask;
  logic [WW-1:0]    w_push;
  logic [WW-1:0]    dec_win;
  logic [CNT_W-1:0] dec_avail;

  logic                   d_close;
  logic [LEN_W-1:0]       d_cnt;
  logic [PAT_BYTES*8-1:0] d_bytes;
  logic [SLOT_W-1:0]      d_slot;
  logic                   d_delim;
  logic                   fin_valid;
  out_kind_t              fin_kind;
  logic                   ends_item;
  logic [LEN_W-1:0]       k;

  logic [LEN_W-1:0]       rem_cnt;
  logic [PAT_BYTES*8-1:0] rem_bytes;
  logic                   r_valid;
  result_t                r;
  logic                   done;

  mdt_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Window with the held data byte appended at the fill position.
  assign byte_mask = ~(WW'(8'hFF) << {window_count, 3'b000});
  assign w_push    = (window & byte_mask) | (WW'(held_item.in_byte) << {window_count, 3'b000});

  // A data byte decides on the full window; an end of string drains what is left.
  assign dec_win   = (held_item.kind == KIND_DATA) ? w_push : window;
  assign dec_avail = (held_item.kind == KIND_DATA) ? CNT_W'(MAX_DELIM_LEN) : window_count;

  mdt_match #(
    .NUM_SLOTS     (NUM_SLOTS),
    .MAX_DELIM_LEN (MAX_DELIM_LEN)
  ) u_match (
    .cfg    (cfg),
    .window (dec_win),
    .avail  (dec_avail),
    .match  (match)
  );

  // Pick what this step works on: the pending delimiter bytes, a fresh
  // decision at the window head, or the close of the string.
  always_comb begin
    d_close           = 1'b0;
    d_cnt             = '0;
    d_bytes           = '0;
    d_slot            = '0;
    d_delim           = 1'b0;
    fin_valid         = 1'b0;
    fin_kind          = OUT_TOKEN_END;
    ends_item         = 1'b0;
    k                 = LEN_W'(1);
    window_next       = window;
    window_count_next = window_count;
    token_open_next   = token_open;
    seen_byte_next    = seen_byte;
    if (burst_cnt != '0) begin
      d_cnt     = burst_cnt;
      d_bytes   = burst_bytes;
      d_slot    = burst_slot;
      d_delim   = 1'b1;
      ends_item = (held_item.kind == KIND_DATA);
    end else if ((held_item.kind == KIND_DATA) &&
                 (window_count != CNT_W'(MAX_DELIM_LEN - 1))) begin
      window_next       = w_push;
      window_count_next = window_count + CNT_W'(1);
      seen_byte_next    = 1'b1;
      ends_item         = 1'b1;
    end else if ((held_item.kind == KIND_DATA) || (window_count != '0)) begin
      if (held_item.kind == KIND_DATA) begin
        seen_byte_next = 1'b1;
        ends_item      = 1'b1;
      end
      d_bytes = (PAT_BYTES*8)'(dec_win);
      if (match.hit) begin
        d_close         = token_open;
        d_cnt           = cfg.emit_delims ? match.len : '0;
        d_slot          = match.slot;
        d_delim         = 1'b1;
        k               = match.len;
        token_open_next = 1'b0;
      end else begin
        d_cnt           = LEN_W'(1);
        token_open_next = 1'b1;
      end
      window_next       = dec_win >> {k, 3'b000};
      window_count_next = dec_avail - CNT_W'(k);
    end else begin
      fin_valid       = token_open || !seen_byte;
      fin_kind        = token_open ? OUT_TOKEN_END : OUT_EMPTY_TOKEN;
      token_open_next = 1'b0;
      seen_byte_next  = 1'b0;
      ends_item       = 1'b1;
    end
  end

  // Produce one result from the chosen work and keep the rest.
  always_comb begin
    rem_cnt   = d_cnt;
    rem_bytes = d_bytes;
    r_valid   = 1'b0;
    r         = '0;
    if (d_close) begin
      r_valid    = 1'b1;
      r.out_kind = OUT_TOKEN_END;
    end else if (d_cnt != '0) begin
      r_valid     = 1'b1;
      r.out_kind  = d_delim ? OUT_DELIM_BYTE : OUT_TOKEN_BYTE;
      r.out_byte  = d_bytes[7:0];
      r.slot_hit  = d_delim ? d_slot : '0;
      r.delim_end = d_delim && (d_cnt == LEN_W'(1));
      rem_cnt     = d_cnt - LEN_W'(1);
      rem_bytes   = d_bytes >> 8;
    end else if (fin_valid) begin
      r_valid    = 1'b1;
      r.out_kind = fin_kind;
    end
    done = ends_item && (rem_cnt == '0);
  end

  assign step.fire       = take && held_valid;
  assign step.has_result = r_valid;
  assign step.result     = r;
  assign step.done       = done;

  assign item_ready = !held_valid || (step.fire && done);

  // Input register and engine state.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid   <= 1'b0;
      window       <= '0;
      window_count <= '0;
      token_open   <= 1'b0;
      seen_byte    <= 1'b0;
      burst_cnt    <= '0;
    end else begin
      if (step.fire) begin
        burst_cnt    <= rem_cnt;
        burst_bytes  <= rem_bytes;
        burst_slot   <= d_slot;
        window       <= window_next;
        window_count <= window_count_next;
        token_open   <= token_open_next;
        seen_byte    <= seen_byte_next;
        if (done) begin
          held_valid <= 1'b0;
        end
      end
      if (item_valid && item_ready) begin
        held_valid <= 1'b1;
        held_item  <= item;
      end
    end
  end

  mdt_result_stage u_result (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .take      (take),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  a_window_not_full: assert property (@(posedge clk) disable iff (rst)
    32'(window_count) < MAX_DELIM_LEN)
    else $error("window left full between items");

  a_burst_has_item: assert property (@(posedge clk) disable iff (rst)
    (burst_cnt != '0) |-> held_valid)
    else $error("delimiter bytes pending without an item in progress");

  a_burst_len: assert property (@(posedge clk) disable iff (rst)
    32'(burst_cnt) <= PAT_BYTES)
    else $error("pending delimiter byte count too large");

endmodule
